[sv/reactive_navigation_fsm_macros.svh]
// ----------------------------------------------------------------------------
// reactive navigation assertion macros
// shared property shorthands for the navigation controller
// ----------------------------------------------------------------------------
`ifndef REACTIVE_NAVIGATION_FSM_MACROS_SVH
`define REACTIVE_NAVIGATION_FSM_MACROS_SVH

// same-cycle implication under reset
`define RNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rnf assertion failed");

// next-cycle implication under reset
`define RNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rnf assertion failed");

`endif

[sv/rnf_pkg.sv]
// ----------------------------------------------------------------------------
// rnf_pkg
// types and constants shared by the navigation controller modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnf_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_TURN    = 3'd2,
    MODE_WALL    = 3'd3,
    MODE_SPIRAL  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ADV_THRESHOLD = 2'd0,
    CFG_WALL_DISTANCE = 2'd1,
    CFG_MAX_ADVANCE   = 2'd2,
    CFG_MAX_ROTATION  = 2'd3
  } cfg_idx_e;

  localparam int unsigned DistW   = 16;
  localparam int unsigned AdvW    = 12;
  localparam int unsigned RotW    = 13;
  localparam int unsigned StepsW  = 10;
  localparam int unsigned QuotW   = 20;
  localparam int unsigned DivisW  = 13;
  localparam int unsigned DivCntW = 5;

  localparam logic [QuotW-1:0] SpiralDividend = 20'd1000000;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[sv/reactive_navigation_fsm.sv]
// ----------------------------------------------------------------------------
// reactive_navigation_fsm
// wander controller: mode rules, speed commands and spiral rotation
// ----------------------------------------------------------------------------
// result: the item is captured and evaluated; on a spiral tick that stays in
// spiral it is then divided in 20 steps of the one-bit-per-cycle divider
// before it is loaded into a free output register; one item at a time
// reset: mode idle, spiral step count zero, configuration registers to their defaults, output valid low
`timescale 1ns / 1ps

`include "reactive_navigation_fsm_macros.svh"

module reactive_navigation_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // front_dist, left_dist, right_dist, nearest_dist, coin
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // next_mode, advance_speed, rotation_speed
  output logic [31:0] m_axis_tdata_o
);

  rnf_pkg::cmd_t cmd;
  rnf_pkg::sts_t sts;

  logic [2:0]                      out_mode;
  logic [rnf_pkg::AdvW-1:0]        out_adv;
  logic signed [rnf_pkg::RotW-1:0] out_rot;

  rnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rnf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .front_i     (s_axis_tdata_i[15:0]),
    .left_i      (s_axis_tdata_i[31:16]),
    .right_i     (s_axis_tdata_i[47:32]),
    .nearest_i   (s_axis_tdata_i[63:48]),
    .coin_i      (s_axis_tdata_i[64]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_mode_o  (out_mode),
    .out_adv_o   (out_adv),
    .out_rot_o   (out_rot)
  );

  assign m_axis_tdata_o = {4'b0000, out_rot, out_adv, out_mode};

  logic in_xfer, out_spiral, out_turn;

  // a spiral step carries speed 500, entering the spiral from forward or turn carries speed 0
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_spiral = m_axis_tvalid_o && (out_mode == 3'(rnf_pkg::MODE_SPIRAL)) &&
                      (out_adv != '0);
  assign out_turn   = m_axis_tvalid_o && (out_mode == 3'(rnf_pkg::MODE_TURN));

  `RNF_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !s_axis_tready_o)
  `RNF_ASSERT_IMP(a_spiral_rot_range, clk_i, rst_ni, out_spiral,
                  (out_rot >= 13'sd100) && (out_rot <= 13'sd800))
  `RNF_ASSERT_IMP(a_turn_stands, clk_i, rst_ni, out_turn, out_adv == '0)

endmodule

[sv/rnf_ctrl.sv]
// ----------------------------------------------------------------------------
// rnf_ctrl
// sequencer: capture, evaluate, optional divide, hand result to output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rnf_pkg::sts_t sts_i,
  output rnf_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/rnf_dp.sv]
// ----------------------------------------------------------------------------
// rnf_dp
// registers, mode rules, spiral divider and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_addr_i,
  input  logic [rnf_pkg::DistW-1:0]         cfg_data_i,
  input  logic [rnf_pkg::DistW-1:0]         front_i,
  input  logic [rnf_pkg::DistW-1:0]         left_i,
  input  logic [rnf_pkg::DistW-1:0]         right_i,
  input  logic [rnf_pkg::DistW-1:0]         nearest_i,
  input  logic                              coin_i,
  input  rnf_pkg::cmd_t                     cmd_i,
  output rnf_pkg::sts_t                     sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [2:0]                        out_mode_o,
  output logic [rnf_pkg::AdvW-1:0]          out_adv_o,
  output logic signed [rnf_pkg::RotW-1:0]   out_rot_o
);

  localparam int unsigned DW = rnf_pkg::DistW;

  // configuration
  logic [15:0] thr_q, wall_q;
  logic [10:0] amax_q;
  logic [11:0] rmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 16'd500;
      wall_q <= 16'd500;
      amax_q <= 11'd1000;
      rmax_q <= 12'd1000;
    end else if (cfg_we_i) begin
      case (rnf_pkg::cfg_idx_e'(cfg_addr_i))
        rnf_pkg::CFG_ADV_THRESHOLD: thr_q  <= cfg_data_i;
        rnf_pkg::CFG_WALL_DISTANCE: wall_q <= cfg_data_i;
        rnf_pkg::CFG_MAX_ADVANCE:   amax_q <= cfg_data_i[10:0];
        rnf_pkg::CFG_MAX_ROTATION:  rmax_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [DW-1:0] f_q, l_q, r_q, n_q;
  logic          coin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      f_q    <= front_i;
      l_q    <= left_i;
      r_q    <= right_i;
      n_q    <= nearest_i;
      coin_q <= coin_i;
    end
  end

  // state
  rnf_pkg::mode_e                mode_q;
  logic [rnf_pkg::StepsW-1:0]    steps_q;

  // scaled comparisons
  logic [19:0] f10, t7, f2, t5;
  logic [16:0] t2;
  logic        fwd_turn, fwd_spiral;
  logic signed [rnf_pkg::RotW-1:0] avoid_rot;

  assign f10 = 20'(f_q) * 20'd10;
  assign t7  = 20'(thr_q) * 20'd7;
  assign f2  = 20'(f_q) * 20'd2;
  assign t5  = 20'(thr_q) * 20'd5;
  assign t2  = 17'(thr_q) * 17'd2;
  assign fwd_turn   = f10 < t7;
  assign fwd_spiral = (f2 > t5) && (17'(l_q) > t2) && (17'(r_q) > t2);
  assign avoid_rot  = (l_q < r_q) ? 13'sd500 : -13'sd500;

  // wall following
  logic            use_right;
  logic [DW-1:0]   side_d;
  logic [22:0]     d100, w85, w115;
  logic signed [rnf_pkg::RotW-1:0] wall_rot;

  assign use_right = r_q < l_q;
  assign side_d    = use_right ? r_q : l_q;
  assign d100      = 23'(side_d) * 23'd100;
  assign w85       = 23'(wall_q) * 23'd85;
  assign w115      = 23'(wall_q) * 23'd115;

  always_comb begin
    wall_rot = '0;
    if (d100 < w85) begin
      wall_rot = use_right ? 13'sd300 : -13'sd300;
    end else if (d100 > w115) begin
      wall_rot = use_right ? -13'sd300 : 13'sd300;
    end
  end

  // speed scalings by reciprocal multiply
  logic [13:0] a6;
  logic [15:0] a21;
  logic [31:0] p5, p25;
  logic [rnf_pkg::AdvW-1:0] spd_hi, spd_lo;

  assign a6     = 14'(amax_q) * 14'd6;
  assign a21    = 16'(amax_q) * 16'd21;
  assign p5     = 32'(a6) * 32'd52429;
  assign p25    = 32'(a21) * 32'd41944;
  assign spd_hi = p5[29:18];
  assign spd_lo = p25[31:20];

  // spiral
  logic [rnf_pkg::StepsW-1:0] steps_inc;
  logic [rnf_pkg::DivisW-1:0] twice_r;
  logic                       spiral_exit;

  assign steps_inc   = (steps_q == '1) ? steps_q : steps_q + 1'b1;
  assign twice_r     = 13'd85 + 13'(steps_inc) * 13'd6;
  assign spiral_exit = (f_q < 16'd400) || (l_q < 16'd125) || (r_q < 16'd125) ||
                       (twice_r > 13'd6000);

  // decision
  rnf_pkg::mode_e                  dec_mode;
  logic [rnf_pkg::AdvW-1:0]        dec_adv;
  logic signed [rnf_pkg::RotW-1:0] dec_rot;
  logic                            dec_div, dec_spiral, dec_fwd;

  always_comb begin
    dec_spiral = 1'b0;
    dec_fwd    = 1'b0;
    dec_mode   = rnf_pkg::MODE_IDLE;
    dec_adv    = '0;
    dec_rot    = '0;
    dec_div    = 1'b0;
    case (mode_q)
      rnf_pkg::MODE_FORWARD: dec_fwd = 1'b1;
      rnf_pkg::MODE_SPIRAL:  dec_spiral = 1'b1;
      rnf_pkg::MODE_TURN: begin
        if (f_q > thr_q) begin
          dec_mode = coin_q ? rnf_pkg::MODE_WALL : rnf_pkg::MODE_SPIRAL;
          dec_adv  = coin_q ? 12'(amax_q) : '0;
        end else begin
          dec_mode = rnf_pkg::MODE_TURN;
          dec_rot  = $signed({1'b0, rmax_q});
        end
      end
      rnf_pkg::MODE_WALL: begin
        if (f_q < thr_q) begin
          dec_mode = rnf_pkg::MODE_TURN;
          dec_rot  = avoid_rot;
        end else begin
          dec_mode = rnf_pkg::MODE_WALL;
          dec_rot  = wall_rot;
          dec_adv  = (wall_rot == 13'sd0) ? spd_hi : spd_lo;
        end
      end
      default: begin
        dec_spiral = n_q > 16'd250;
        dec_fwd    = !(n_q > 16'd250);
      end
    endcase
    if (dec_fwd) begin
      if (fwd_turn) begin
        dec_mode = rnf_pkg::MODE_TURN;
        dec_rot  = avoid_rot;
      end else if (fwd_spiral) begin
        dec_mode = rnf_pkg::MODE_SPIRAL;
      end else begin
        dec_mode = rnf_pkg::MODE_FORWARD;
        dec_adv  = 12'(amax_q);
      end
    end
    if (dec_spiral) begin
      if (spiral_exit) begin
        dec_mode = rnf_pkg::MODE_FORWARD;
        dec_adv  = 12'd450;
      end else begin
        dec_mode = rnf_pkg::MODE_SPIRAL;
        dec_adv  = 12'd500;
        dec_div  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rnf_pkg::MODE_IDLE;
      steps_q <= '0;
    end else if (cmd_i.eval) begin
      mode_q <= dec_mode;
      if (dec_spiral) begin
        steps_q <= steps_inc;
      end
    end
  end

  // latched decision and restoring divider, one quotient bit per cycle
  rnf_pkg::mode_e                  res_mode_q;
  logic [rnf_pkg::AdvW-1:0]        res_adv_q;
  logic signed [rnf_pkg::RotW-1:0] res_rot_q;
  logic                            res_div_q;
  logic [rnf_pkg::DivisW-1:0]      divisor_q, rem_q;
  logic [rnf_pkg::QuotW-1:0]       dq_q;
  logic [rnf_pkg::DivCntW-1:0]     cnt_q;
  logic [rnf_pkg::DivisW:0]        trial;
  logic                            fits;

  assign trial = {rem_q, dq_q[rnf_pkg::QuotW-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_mode_q <= dec_mode;
      res_adv_q  <= dec_adv;
      res_rot_q  <= dec_rot;
      res_div_q  <= dec_div;
      divisor_q  <= twice_r;
      rem_q      <= '0;
      dq_q       <= rnf_pkg::SpiralDividend;
      cnt_q      <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? rnf_pkg::DivisW'(trial - {1'b0, divisor_q})
                    : trial[rnf_pkg::DivisW-1:0];
      dq_q  <= {dq_q[rnf_pkg::QuotW-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // clamp to 100..800
  logic [9:0] omega;

  always_comb begin
    if (dq_q > 20'd800) begin
      omega = 10'd800;
    end else if (dq_q < 20'd100) begin
      omega = 10'd100;
    end else begin
      omega = dq_q[9:0];
    end
  end

  assign sts_o.need_div = dec_div;
  assign sts_o.div_last = cnt_q == rnf_pkg::DivCntW'(rnf_pkg::QuotW - 1);
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mode_o <= res_mode_q;
      out_adv_o  <= res_adv_q;
      out_rot_o  <= res_div_q ? $signed({3'b000, omega}) : res_rot_q;
    end
  end

endmodule
